### design/abb_pkg.sv
package abb_pkg;

  // Configuration register width and write port index width
  localparam int CFG_W     = 13;
  localparam int REG_IDX_W = 3;

  typedef logic [REG_IDX_W-1:0] reg_index_t;

  // Register indexes on the configuration port
  localparam reg_index_t REG_SOURCE_WIDTH  = 3'd0;
  localparam reg_index_t REG_SOURCE_HEIGHT = 3'd1;
  localparam reg_index_t REG_DEST_WIDTH    = 3'd2;
  localparam reg_index_t REG_DEST_HEIGHT   = 3'd3;
  localparam reg_index_t REG_OFFSET_X      = 3'd4;
  localparam reg_index_t REG_OFFSET_Y      = 3'd5;
  localparam reg_index_t REG_BLEND_MODE    = 3'd6;

  // Reset values
  localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd16;
  localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd16;
  localparam logic [CFG_W-1:0] RST_DEST_WIDTH    = 13'd640;
  localparam logic [CFG_W-1:0] RST_DEST_HEIGHT   = 13'd480;

  // Blend modes
  localparam logic MODE_PRECISE = 1'b0;
  localparam logic MODE_FAST    = 1'b1;

  typedef logic [31:0] pixel_t;
  typedef logic [23:0] index_t;
  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [CFG_W-1:0]        source_width;
    logic [CFG_W-1:0]        source_height;
    logic [CFG_W-1:0]        dest_width;
    logic [CFG_W-1:0]        dest_height;
    logic signed [CFG_W-1:0] offset_x;
    logic signed [CFG_W-1:0] offset_y;
    logic                    blend_mode;
  } cfg_t;

endpackage

### design/abb_if.sv
// Pixel pair channel: source pixel with the matching destination pixel
interface abb_pixel_if;
  logic            valid;
  logic            ready;
  abb_pkg::pixel_t source_pixel;
  abb_pkg::pixel_t dest_pixel;

  modport source (output valid, output source_pixel, output dest_pixel, input ready);
  modport sink   (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

// Result channel: destination write
interface abb_result_if;
  logic            valid;
  logic            ready;
  abb_pkg::index_t dest_index;
  abb_pkg::rgb_t   blended_color;
  logic            write_enable;
  logic            last_pixel;

  modport source (output valid, output dest_index, output blended_color,
                  output write_enable, output last_pixel, input ready);
  modport sink   (input valid, input dest_index, input blended_color,
                  input write_enable, input last_pixel, output ready);
endinterface

### design/abb_raster.sv
// Column and row walker over the source bitmap
module abb_raster #(
  parameter int MAX_DIMENSION = 4096,
  parameter int CW            = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  abb_pkg::cfg_t   cfg,
  output logic [CW-1:0]   column,
  output logic [CW-1:0]   row,
  output logic            last
);
  import abb_pkg::*;

  localparam int SW = CFG_W + 1;
  localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_DIMENSION);

  logic [SW-1:0] width_eff;
  logic [SW-1:0] height_eff;
  logic [SW-1:0] column_inc;
  logic [SW-1:0] row_inc;
  logic          column_wrap;
  logic          row_wrap;
  logic [CW-1:0] column_next;
  logic [CW-1:0] row_next;

  // Clamp source size into 1..MAX_DIMENSION
  always_comb begin
    priority if (cfg.source_width == '0) begin
      width_eff = SW'(1);
    end else if (SW'(cfg.source_width) > MAX_SIZE) begin
      width_eff = MAX_SIZE;
    end else begin
      width_eff = SW'(cfg.source_width);
    end
    priority if (cfg.source_height == '0) begin
      height_eff = SW'(1);
    end else if (SW'(cfg.source_height) > MAX_SIZE) begin
      height_eff = MAX_SIZE;
    end else begin
      height_eff = SW'(cfg.source_height);
    end
  end

  assign column_inc  = SW'(column) + SW'(1);
  assign row_inc     = SW'(row) + SW'(1);
  assign column_wrap = column_inc >= width_eff;
  assign row_wrap    = row_inc >= height_eff;
  assign last        = (column_inc == width_eff) && (row_inc == height_eff);

  // Raster step
  always_comb begin
    column_next = column;
    row_next    = row;
    if (column_wrap) begin
      column_next = '0;
      row_next    = row_wrap ? '0 : row_inc[CW-1:0];
    end else begin
      column_next = column_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (advance) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

### design/abb_blend.sv
// Color blend, source alpha weights the destination pixel
module abb_blend (
  input  abb_pkg::pixel_t source_pixel,
  input  abb_pkg::pixel_t dest_pixel,
  input  logic            blend_mode,
  output abb_pkg::rgb_t   blended_color
);
  import abb_pkg::*;

  logic [8:0]  alpha;
  logic [8:0]  alpha_inv;
  logic [16:0] red_sum;
  logic [16:0] green_sum;
  logic [16:0] blue_src;
  logic [16:0] blue_dst;
  logic [8:0]  blue_sum;
  rgb_t        precise_color;

  logic [3:0]  alpha_n;
  logic [3:0]  alpha_n_inv;
  logic [7:0]  fast_chan [3];
  rgb_t        fast_color;

  // Precise 8-bit blend; blue rounds each product down separately
  assign alpha     = {1'b0, source_pixel[31:24]};
  assign alpha_inv = 9'h100 - alpha;
  assign red_sum   = 17'(alpha_inv * source_pixel[23:16]) + 17'(alpha * dest_pixel[23:16]);
  assign green_sum = 17'(alpha_inv * source_pixel[15:8]) + 17'(alpha * dest_pixel[15:8]);
  assign blue_src  = 17'(alpha_inv * source_pixel[7:0]);
  assign blue_dst  = 17'(alpha * dest_pixel[7:0]);
  assign blue_sum  = {1'b0, blue_src[15:8]} + {1'b0, blue_dst[15:8]};
  assign precise_color = {red_sum[15:8], green_sum[15:8], blue_sum[7:0]};

  // Fast blend on high nibbles
  assign alpha_n     = source_pixel[31:28];
  assign alpha_n_inv = 4'hF - alpha_n;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fast_chan[k] = 8'(alpha_n_inv * source_pixel[8*k+4 +: 4])
                   + 8'(alpha_n * dest_pixel[8*k+4 +: 4]);
    end
  end

  assign fast_color = {fast_chan[2], fast_chan[1], fast_chan[0]};

  assign blended_color = (blend_mode == MODE_FAST) ? fast_color : precise_color;

endmodule

### design/abb_clip.sv
// Destination position, linear index and edge clipping
module abb_clip #(
  parameter int CW = 12
) (
  input  abb_pkg::cfg_t   cfg,
  input  logic [CW-1:0]   column,
  input  logic [CW-1:0]   row,
  output abb_pkg::index_t dest_index,
  output logic            write_enable
);
  import abb_pkg::*;

  // Position width: holds counter plus signed offset
  localparam int PW = ((CW + 1 > CFG_W) ? CW + 1 : CFG_W) + 1;
  localparam int MW = CFG_W + 1 + PW;

  logic signed [PW-1:0] pos_x;
  logic signed [PW-1:0] pos_y;
  logic signed [MW-1:0] row_base;
  logic [23:0]          pos_x_ext;

  assign pos_x = $signed({{(PW-CW){1'b0}}, column})
               + $signed({{(PW-CFG_W){cfg.offset_x[CFG_W-1]}}, cfg.offset_x});
  assign pos_y = $signed({{(PW-CW){1'b0}}, row})
               + $signed({{(PW-CFG_W){cfg.offset_y[CFG_W-1]}}, cfg.offset_y});

  // Inside the buffer on all four sides
  assign write_enable = !pos_x[PW-1] && !pos_y[PW-1]
                     && (pos_x < $signed({{(PW-CFG_W){1'b0}}, cfg.dest_width}))
                     && (pos_y < $signed({{(PW-CFG_W){1'b0}}, cfg.dest_height}));

  // Index wraps modulo 2^24, also off the buffer
  assign row_base  = $signed({1'b0, cfg.dest_width}) * pos_y;
  assign pos_x_ext = {{(24-PW){pos_x[PW-1]}}, pos_x};
  assign dest_index = row_base[23:0] + pos_x_ext;

endmodule

### design/alpha_blend_blitter.sv
// Alpha-blended block transfer of a source bitmap into a frame buffer.
// pixel_in carries one source pixel per transaction in raster order, paired
// with the destination pixel at the matching position. result_out carries
// the linear destination index, the blended RGB value, a write enable that
// is low off any edge of the destination, and a mark on the bitmap's final
// pixel. Registers are written on cfg_write with cfg_index / cfg_data. The
// user writes them only while no pixel is in flight; the block does not
// enforce this. Throughput: one pixel per clock while result_out does not
// stall. A pixel passes through the input register, then the result
// register, with the blend and index multiply between them.
// When result_out stalls, the result register holds and the input register
// fills; pixel_in.ready drops only when both are occupied.
// Reset clears the registers to their defaults, empties the pipeline and
// returns the column and row counters to the bitmap origin.
module alpha_blend_blitter #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  abb_pkg::reg_index_t    cfg_index,
  input  logic [abb_pkg::CFG_W-1:0] cfg_data,
  abb_pixel_if.sink              pixel_in,
  abb_result_if.source           result_out
);
  import abb_pkg::*;

  localparam int CW = $clog2(MAX_DIMENSION);

  cfg_t          cfg;
  logic          in_take;
  logic          s1_valid;
  logic          s1_ready;
  pixel_t        s1_source;
  pixel_t        s1_dest;
  logic [CW-1:0] s1_column;
  logic [CW-1:0] s1_row;
  logic          s1_last;
  logic          out_ready;

  logic [CW-1:0] cur_column;
  logic [CW-1:0] cur_row;
  logic          cur_last;
  rgb_t          color_comb;
  index_t        index_comb;
  logic          we_comb;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= RST_SOURCE_WIDTH;
      cfg.source_height <= RST_SOURCE_HEIGHT;
      cfg.dest_width    <= RST_DEST_WIDTH;
      cfg.dest_height   <= RST_DEST_HEIGHT;
      cfg.offset_x      <= '0;
      cfg.offset_y      <= '0;
      cfg.blend_mode    <= MODE_PRECISE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: cfg.source_height <= cfg_data;
        REG_DEST_WIDTH:    cfg.dest_width    <= cfg_data;
        REG_DEST_HEIGHT:   cfg.dest_height   <= cfg_data;
        REG_OFFSET_X:      cfg.offset_x      <= cfg_data;
        REG_OFFSET_Y:      cfg.offset_y      <= cfg_data;
        REG_BLEND_MODE:    cfg.blend_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake through the two register stages
  assign out_ready      = !result_out.valid || result_out.ready;
  assign s1_ready       = !s1_valid || out_ready;
  assign pixel_in.ready = s1_ready;
  assign in_take        = pixel_in.valid && s1_ready;

  abb_raster #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .CW            (CW)
  ) u_raster (
    .clk     (clk),
    .rst     (rst),
    .advance (in_take),
    .cfg     (cfg),
    .column  (cur_column),
    .row     (cur_row),
    .last    (cur_last)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_source <= pixel_in.source_pixel;
      s1_dest   <= pixel_in.dest_pixel;
      s1_column <= cur_column;
      s1_row    <= cur_row;
      s1_last   <= cur_last;
    end
  end

  abb_blend u_blend (
    .source_pixel  (s1_source),
    .dest_pixel    (s1_dest),
    .blend_mode    (cfg.blend_mode),
    .blended_color (color_comb)
  );

  abb_clip #(
    .CW (CW)
  ) u_clip (
    .cfg          (cfg),
    .column       (s1_column),
    .row          (s1_row),
    .dest_index   (index_comb),
    .write_enable (we_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (out_ready) begin
      result_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      result_out.dest_index    <= index_comb;
      result_out.blended_color <= color_comb;
      result_out.write_enable  <= we_comb;
      result_out.last_pixel    <= s1_last;
    end
  end

endmodule
